// File: sv/iarp_pkg.sv
package iarp_pkg;

   localparam int ID_DIGITS       = 11;
   localparam int AMOUNT_BITS     = 32;
   localparam int ID_BITS         = 4 * ID_DIGITS;
   localparam int ID_CNT_BITS     = $clog2(ID_DIGITS + 1);
   localparam int ID_OUT_BITS     = 44;
   localparam int AMOUNT_OUT_BITS = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   typedef enum logic [1:0] {
      PHASE_INT,
      PHASE_TENTHS,
      PHASE_HUNDREDTHS
   } phase_type;

   typedef struct packed {
      logic       is_digit;
      logic       is_point;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic [ID_OUT_BITS-1:0]     id_bcd;
      logic [AMOUNT_OUT_BITS-1:0] amount_cents;
   } result_type;

   // acc * 10 + digit, clamped to the all-ones amount
   function automatic logic [AMOUNT_BITS-1:0] sat_mul10_add(
      input logic [AMOUNT_BITS-1:0] acc,
      input logic [3:0]             digit
   );
      logic [AMOUNT_BITS+3:0] wide;
      wide = {acc, 3'b000} + {2'b00, acc, 1'b0} + (AMOUNT_BITS + 4)'(digit);
      if (wide[AMOUNT_BITS+3:AMOUNT_BITS] != 4'd0) begin
         return '1;
      end
      return wide[AMOUNT_BITS-1:0];
   endfunction

endpackage

// File: sv/iarp_front.sv
module iarp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_char_in,
   output logic               item_valid,
   input  logic               item_take,
   output iarp_pkg::item_type item
);

   iarp_pkg::item_type cls;
   iarp_pkg::item_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_en;
   logic       rd_en;

   always_comb begin
      cls.is_digit = (req_char_in >= iarp_pkg::CHAR_ZERO) &&
                     (req_char_in <= iarp_pkg::CHAR_NINE);
      cls.is_point = (req_char_in == iarp_pkg::CHAR_POINT);
      cls.digit    = 4'(req_char_in - iarp_pkg::CHAR_ZERO);
   end

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = mem_ff[rd_ptr_ff];

   // drop characters that cannot change the record
   assign wr_en = req_push && !req_full && (cls.is_digit || cls.is_point);
   assign rd_en = item_take && item_valid;

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (rd_en) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 2'd1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: sv/iarp_back.sv
module iarp_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   item_valid,
   output logic                                   item_take,
   input  iarp_pkg::item_type                     item,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [iarp_pkg::ID_OUT_BITS-1:0]       rsp_id_bcd,
   output logic [iarp_pkg::AMOUNT_OUT_BITS-1:0]   rsp_amount_cents
);

   logic [iarp_pkg::ID_CNT_BITS-1:0] id_count_ff, id_count_in;
   logic [iarp_pkg::ID_BITS-1:0]     id_store_ff, id_store_in;
   iarp_pkg::phase_type              phase_ff, phase_in;
   logic [iarp_pkg::AMOUNT_BITS-1:0] amount_ff, amount_in;
   logic [iarp_pkg::AMOUNT_BITS-1:0] amount_next;
   logic                             id_done;
   logic                             emit;
   iarp_pkg::result_type             result;

   iarp_pkg::result_type out_mem_ff [2];
   logic [1:0] out_count_ff, out_count_in;
   logic       out_wr_ptr_ff, out_wr_ptr_in;
   logic       out_rd_ptr_ff, out_rd_ptr_in;
   logic       out_rd_en;

   assign item_take   = item_valid && (out_count_ff != 2'd2);
   assign id_done     = (id_count_ff == iarp_pkg::ID_CNT_BITS'(iarp_pkg::ID_DIGITS));
   assign amount_next = iarp_pkg::sat_mul10_add(amount_ff, item.digit);

   always_comb begin
      id_count_in = id_count_ff;
      id_store_in = id_store_ff;
      phase_in    = phase_ff;
      amount_in   = amount_ff;
      emit        = 1'b0;
      result.id_bcd       = iarp_pkg::ID_OUT_BITS'(id_store_ff);
      result.amount_cents = iarp_pkg::AMOUNT_OUT_BITS'(amount_next);
      if (item_take) begin
         if (item.is_digit) begin
            if (!id_done) begin
               id_store_in = (id_store_ff << 4) | iarp_pkg::ID_BITS'(item.digit);
               id_count_in = id_count_ff + iarp_pkg::ID_CNT_BITS'(1);
            end else begin
               case (phase_ff)
                  iarp_pkg::PHASE_INT: begin
                     amount_in = amount_next;
                  end
                  iarp_pkg::PHASE_TENTHS: begin
                     amount_in = amount_next;
                     phase_in  = iarp_pkg::PHASE_HUNDREDTHS;
                  end
                  iarp_pkg::PHASE_HUNDREDTHS: begin
                     // record complete: emit and start over
                     emit        = 1'b1;
                     id_count_in = '0;
                     id_store_in = '0;
                     phase_in    = iarp_pkg::PHASE_INT;
                     amount_in   = '0;
                  end
                  default: begin
                     phase_in = iarp_pkg::PHASE_INT;
                  end
               endcase
            end
         end else if (item.is_point && id_done && (phase_ff == iarp_pkg::PHASE_INT)) begin
            phase_in = iarp_pkg::PHASE_TENTHS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_count_ff <= '0;
         id_store_ff <= '0;
         phase_ff    <= iarp_pkg::PHASE_INT;
         amount_ff   <= '0;
      end else begin
         id_count_ff <= id_count_in;
         id_store_ff <= id_store_in;
         phase_ff    <= phase_in;
         amount_ff   <= amount_in;
      end
   end

   // result queue
   assign rsp_empty        = (out_count_ff == 2'd0);
   assign rsp_id_bcd       = out_mem_ff[out_rd_ptr_ff].id_bcd;
   assign rsp_amount_cents = out_mem_ff[out_rd_ptr_ff].amount_cents;
   assign out_rd_en        = rsp_pop && !rsp_empty;

   always_comb begin
      out_count_in  = out_count_ff;
      out_wr_ptr_in = out_wr_ptr_ff;
      out_rd_ptr_in = out_rd_ptr_ff;
      if (emit) begin
         out_wr_ptr_in = !out_wr_ptr_ff;
      end
      if (out_rd_en) begin
         out_rd_ptr_in = !out_rd_ptr_ff;
      end
      if (emit && !out_rd_en) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (!emit && out_rd_en) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff  <= 2'd0;
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
      end else begin
         out_count_ff  <= out_count_in;
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_mem_ff[out_wr_ptr_ff] <= result;
      end
   end

endmodule

// File: sv/id_and_amount_record_parser_unit.sv
// A record's result reaches the rsp_ ports through the front queue, which
// stores its last hundredths digit, then the record update into the result queue.
// Throughput: one character per cycle while the result queue has room, set by the
// combinational multiply-add in the record stage; a two-entry queue on each side absorbs stalls.
// Reset: synchronous, active high; clears the record state and both queues.
module id_and_amount_record_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_char_in,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [iarp_pkg::ID_OUT_BITS-1:0]     rsp_id_bcd,
   output logic [iarp_pkg::AMOUNT_OUT_BITS-1:0] rsp_amount_cents
);

   logic               item_valid;
   logic               item_take;
   iarp_pkg::item_type item;

   iarp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_char_in (req_char_in),
      .item_valid  (item_valid),
      .item_take   (item_take),
      .item        (item)
   );

   iarp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_take        (item_take),
      .item             (item),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_id_bcd       (rsp_id_bcd),
      .rsp_amount_cents (rsp_amount_cents)
   );

endmodule

// File: sv/iarp_checker.sv
module iarp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_push,
   input logic                                 req_full,
   input logic [7:0]                           req_char_in,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [iarp_pkg::ID_OUT_BITS-1:0]     rsp_id_bcd,
   input logic [iarp_pkg::AMOUNT_OUT_BITS-1:0] rsp_amount_cents
);

   logic bcd_ok;
   logic push_seen;

   always_comb begin
      bcd_ok = 1'b1;
      for (int i = 0; i < iarp_pkg::ID_OUT_BITS / 4; i++) begin
         if (rsp_id_bcd[4*i +: 4] > 4'd9) begin
            bcd_ok = 1'b0;
         end
      end
   end

   // only digits and points take a slot in the front queue
   assign push_seen = req_push &&
                      (((req_char_in >= iarp_pkg::CHAR_ZERO) &&
                        (req_char_in <= iarp_pkg::CHAR_NINE)) ||
                       (req_char_in == iarp_pkg::CHAR_POINT));

   // queues come out of reset empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   // no result can appear right after reset
   a_no_early_result: assert property (@(posedge clock)
      reset |=> rsp_empty ##1 rsp_empty ##1 rsp_empty)
      else $error("result too soon after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_id_bcd) &&
         $stable(rsp_amount_cents))
      else $error("waiting result changed");

   a_id_is_bcd: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> bcd_ok)
      else $error("identifier digit out of range");

   // full can only rise after a digit or a point is offered
   a_full_needs_push: assert property (@(posedge clock)
      !req_full && !push_seen |=> !req_full)
      else $error("input went full with nothing pushed");

endmodule

bind id_and_amount_record_parser_unit iarp_checker u_iarp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .req_char_in      (req_char_in),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_id_bcd       (rsp_id_bcd),
   .rsp_amount_cents (rsp_amount_cents)
);
